### rtl/mwr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwr_pkg
// Shared types and constants for the Microwire EEPROM word reader.
// ----------------------------------------------------------------------------
package mwr_pkg;

    localparam int DATA_BITS_DEF     = 16;
    localparam int MAX_ADDR_BITS_DEF = 10;
    localparam int OPCODE_BITS       = 2;

    localparam int WORD_W    = 16;
    localparam int ADDR_IN_W = 10;
    localparam int ABITS_W   = 4;
    localparam int SCAN_W    = 11;
    localparam int CNT_W     = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam int SCAN_LIMIT = 1024;

    localparam logic [OPCODE_BITS-1:0] READ_OPCODE = 2'b10;
    localparam logic [1:0]             MARK_DIFF   = 2'd2;

    localparam logic [ABITS_W-1:0] ABITS_RESET = 4'd8;
    localparam logic [SCAN_W-1:0]  SCAN_RESET  = 11'd256;

    // action codes
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_SCAN = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_ABITS = 1'b0;
    localparam logic REG_SCAN  = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SELECT,
        PH_START0,
        PH_START1,
        PH_START2,
        PH_SEND,
        PH_RISE,
        PH_FALL,
        PH_DRISE,
        PH_DFALL,
        PH_DSAMPLE,
        PH_DESELECT
    } t_phase;

    typedef struct packed {
        logic [1:0]           action;
        logic [ADDR_IN_W-1:0] word_address;
        logic                 serial_data_in;
    } t_in_item;

    typedef struct packed {
        logic              chip_select;
        logic              serial_clock;
        logic              serial_data_out;
        logic              busy_res;
        logic              word_ready;
        logic [WORD_W-1:0] read_word;
        logic              scan_done;
        logic              checksum_ok;
    } t_out_item;

    typedef struct packed {
        logic [ABITS_W-1:0] address_bits;
        logic [SCAN_W-1:0]  scan_words;
    } t_cfg;

endpackage

### rtl/microwire_eeprom_word_reader_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// microwire_eeprom_word_reader_unit
// Microwire EEPROM read/checksum master, one bit-bang tick per input word.
// ----------------------------------------------------------------------------
// The result word is in the output register in the cycle after accept.
// Throughput: one word per cycle when not stalled; state advances in one pass.
// Input stalls only while a finished result is held and the output stalls.
// Synchronous active-low reset: sequencer idle, address_bits 8, scan_words 256.
module microwire_eeprom_word_reader_unit #(
    parameter int DATA_BITS        = mwr_pkg::DATA_BITS_DEF,
    parameter int MAX_ADDRESS_BITS = mwr_pkg::MAX_ADDR_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  mwr_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output mwr_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mwr_pkg::PADDR_W-1:0] paddr,
    input  logic [mwr_pkg::PDATA_W-1:0] pwdata,
    output logic [mwr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    mwr_pkg::t_cfg      r_cfg;
    mwr_pkg::t_out_item r_out, n_out;
    logic               r_out_valid;
    logic               accept;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mwr_pkg::REG_SCAN) ?
                    mwr_pkg::PDATA_W'(r_cfg.scan_words) :
                    mwr_pkg::PDATA_W'(r_cfg.address_bits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address_bits <= mwr_pkg::ABITS_RESET;
            r_cfg.scan_words   <= mwr_pkg::SCAN_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == mwr_pkg::REG_ABITS) begin
                r_cfg.address_bits <= pwdata[mwr_pkg::ABITS_W-1:0];
            end else begin
                r_cfg.scan_words <= pwdata[mwr_pkg::SCAN_W-1:0];
            end
        end
    end

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    mwr_seq #(
        .DATA_BITS        (DATA_BITS),
        .MAX_ADDRESS_BITS (MAX_ADDRESS_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_item  (i_in_data),
        .i_cfg   (r_cfg),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/mwr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwr_seq
// Pin sequencer: advances one tick per accepted word and forms the result.
// ----------------------------------------------------------------------------
module mwr_seq #(
    parameter int DATA_BITS        = mwr_pkg::DATA_BITS_DEF,
    parameter int MAX_ADDRESS_BITS = mwr_pkg::MAX_ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  mwr_pkg::t_in_item  i_item,
    input  mwr_pkg::t_cfg      i_cfg,
    output mwr_pkg::t_out_item o_res
);

    localparam int AW    = MAX_ADDRESS_BITS;
    localparam int IW    = $clog2(AW);
    localparam int CMP_W = (AW + 1 > mwr_pkg::SCAN_W) ? AW + 1 : mwr_pkg::SCAN_W;
    localparam int CW    = mwr_pkg::CNT_W;
    localparam int WW    = mwr_pkg::WORD_W;

    localparam logic [CW-1:0] AW_C   = CW'(AW);
    localparam logic [CW-1:0] OPC_C  = CW'(mwr_pkg::OPCODE_BITS);
    localparam logic [CW-1:0] DATA_C = CW'(DATA_BITS);
    localparam logic [mwr_pkg::SCAN_W-1:0] LIMIT_C = mwr_pkg::SCAN_W'(mwr_pkg::SCAN_LIMIT);

    mwr_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]        r_bc, n_bc;
    logic [AW-1:0]        r_cmd, n_cmd;
    logic [1:0]           r_prev, n_prev;
    logic [DATA_BITS-1:0] r_ds, n_ds;
    logic [AW-1:0]        r_addr, n_addr;
    logic [WW-1:0]        r_sum, n_sum;
    logic                 r_scan, n_scan;
    logic                 r_sel, n_sel;
    logic                 r_asec, n_asec;
    logic [WW-1:0]        r_last, n_last;

    logic [CW-1:0]             eff_abits;
    logic [mwr_pkg::SCAN_W-1:0] eff_scan;
    logic [CW-1:0]             sec_len;
    logic [CW-1:0]             bit_idx;
    logic                      cur_bit;
    logic [CW-1:0]             bc_inc;
    logic [CMP_W-1:0]          addr_next;

    always_comb begin
        eff_abits = {1'b0, i_cfg.address_bits};
        if (eff_abits == '0) begin
            eff_abits = CW'(1);
        end else if (eff_abits > AW_C) begin
            eff_abits = AW_C;
        end
        eff_scan = i_cfg.scan_words;
        if (eff_scan == '0) begin
            eff_scan = mwr_pkg::SCAN_W'(1);
        end else if (eff_scan > LIMIT_C) begin
            eff_scan = LIMIT_C;
        end
    end

    // opcode and address bits go out MSB first out of the command register
    assign sec_len = r_asec ? eff_abits : OPC_C;
    assign bit_idx = sec_len - CW'(1) - r_bc;
    assign cur_bit = (r_bc >= sec_len) ? 1'b0 : r_cmd[bit_idx[IW-1:0]];
    assign bc_inc  = r_bc + CW'(1);
    assign addr_next = CMP_W'(r_addr) + CMP_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_bc    = r_bc;
        n_cmd   = r_cmd;
        n_prev  = r_prev;
        n_ds    = r_ds;
        n_addr  = r_addr;
        n_sum   = r_sum;
        n_scan  = r_scan;
        n_sel   = r_sel;
        n_asec  = r_asec;
        n_last  = r_last;
        o_res   = '0;

        if (r_phase == mwr_pkg::PH_IDLE &&
            (i_item.action == mwr_pkg::ACT_READ || i_item.action == mwr_pkg::ACT_SCAN)) begin
            n_scan  = (i_item.action == mwr_pkg::ACT_SCAN);
            n_addr  = n_scan ? '0 : AW'(i_item.word_address);
            n_sum   = '0;
            n_phase = mwr_pkg::PH_SELECT;
        end

        o_res.busy_res = (n_phase != mwr_pkg::PH_IDLE);

        case (n_phase)
            mwr_pkg::PH_SELECT: begin
                n_sel   = 1'b1;
                n_phase = mwr_pkg::PH_START0;
            end
            mwr_pkg::PH_START0: begin
                o_res.serial_data_out = 1'b1;
                n_phase = mwr_pkg::PH_START1;
            end
            mwr_pkg::PH_START1: begin
                o_res.serial_data_out = 1'b1;
                o_res.serial_clock    = 1'b1;
                n_phase = mwr_pkg::PH_START2;
            end
            mwr_pkg::PH_START2: begin
                o_res.serial_data_out = 1'b1;
                n_asec  = 1'b0;
                n_cmd   = AW'(mwr_pkg::READ_OPCODE);
                n_bc    = '0;
                n_prev  = mwr_pkg::MARK_DIFF;
                n_phase = mwr_pkg::PH_SEND;
            end
            mwr_pkg::PH_SEND: begin
                o_res.serial_data_out = cur_bit;
                // extra tick to move DO only when the bit changes
                if (r_prev != {1'b0, cur_bit}) begin
                    n_prev  = {1'b0, cur_bit};
                    n_phase = mwr_pkg::PH_RISE;
                end else begin
                    o_res.serial_clock = 1'b1;
                    n_phase = mwr_pkg::PH_FALL;
                end
            end
            mwr_pkg::PH_RISE: begin
                o_res.serial_data_out = cur_bit;
                o_res.serial_clock    = 1'b1;
                n_phase = mwr_pkg::PH_FALL;
            end
            mwr_pkg::PH_FALL: begin
                o_res.serial_data_out = cur_bit;
                n_bc = bc_inc;
                if (bc_inc >= sec_len) begin
                    n_bc = '0;
                    if (!r_asec) begin
                        n_asec  = 1'b1;
                        n_cmd   = r_addr;
                        n_prev  = mwr_pkg::MARK_DIFF;
                        n_phase = mwr_pkg::PH_SEND;
                    end else begin
                        n_ds    = '0;
                        n_phase = mwr_pkg::PH_DRISE;
                    end
                end else begin
                    n_phase = mwr_pkg::PH_SEND;
                end
            end
            mwr_pkg::PH_DRISE: begin
                o_res.serial_clock = 1'b1;
                n_phase = mwr_pkg::PH_DFALL;
            end
            mwr_pkg::PH_DFALL: begin
                n_phase = mwr_pkg::PH_DSAMPLE;
            end
            mwr_pkg::PH_DSAMPLE: begin
                n_ds = {r_ds[DATA_BITS-2:0], i_item.serial_data_in};
                n_bc = bc_inc;
                if (bc_inc >= DATA_C) begin
                    n_bc   = '0;
                    n_last = WW'(n_ds);
                    o_res.word_ready = 1'b1;
                    if (r_scan) begin
                        n_sum = r_sum + WW'(n_ds);
                    end
                    n_phase = mwr_pkg::PH_DESELECT;
                end else begin
                    n_phase = mwr_pkg::PH_DRISE;
                end
            end
            mwr_pkg::PH_DESELECT: begin
                n_sel = 1'b0;
                if (r_scan && addr_next < CMP_W'(eff_scan)) begin
                    n_addr  = addr_next[AW-1:0];
                    n_phase = mwr_pkg::PH_SELECT;
                end else begin
                    if (r_scan) begin
                        o_res.scan_done   = 1'b1;
                        o_res.checksum_ok = (r_sum == '0);
                    end
                    n_scan  = 1'b0;
                    n_phase = mwr_pkg::PH_IDLE;
                end
            end
            default: begin
                n_sel = 1'b0;
                o_res.busy_res = 1'b0;
                n_phase = mwr_pkg::PH_IDLE;
            end
        endcase

        o_res.chip_select = n_sel;
        o_res.read_word   = n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mwr_pkg::PH_IDLE;
            r_bc    <= '0;
            r_cmd   <= '0;
            r_prev  <= mwr_pkg::MARK_DIFF;
            r_ds    <= '0;
            r_addr  <= '0;
            r_sum   <= '0;
            r_scan  <= 1'b0;
            r_sel   <= 1'b0;
            r_asec  <= 1'b0;
            r_last  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_cmd   <= n_cmd;
            r_prev  <= n_prev;
            r_ds    <= n_ds;
            r_addr  <= n_addr;
            r_sum   <= n_sum;
            r_scan  <= n_scan;
            r_sel   <= n_sel;
            r_asec  <= n_asec;
            r_last  <= n_last;
        end
    end

endmodule

### rtl/mwr_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwr_chk
// Port-level checks for the Microwire EEPROM word reader.
// ----------------------------------------------------------------------------
module mwr_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mwr_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted word gave no result");

    a_done_deselect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.scan_done |->
            o_out_data.busy_res && !o_out_data.chip_select && !o_out_data.word_ready)
        else $error("scan done outside the deselect tick");

    a_ok_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.checksum_ok |-> o_out_data.scan_done)
        else $error("checksum_ok without scan_done");

endmodule

bind microwire_eeprom_word_reader_unit mwr_chk u_mwr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### test/microwire_eeprom_word_reader_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// microwire_eeprom_word_reader_unit_test
// Self-checking bench for the Microwire read/checksum sequencer. Every tick
// word is run through a cycle model of the pin sequencer kept in a small
// scoreboard, and each result word is compared field by field. An EEPROM
// image feeds the sampled data bits so scans can be made to sum to zero.
// ----------------------------------------------------------------------------
module microwire_eeprom_word_reader_unit_test;

    localparam logic [1:0] ACT_SPARE      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RANDOM_ITEMS   = 200;
    localparam int         RANDOM_PHASES  = 4;
    localparam int         LONG_HOLD      = 80;

    class eeprom_pin_scoreboard;
        logic [mwr_pkg::ABITS_W-1:0]   address_bits;
        logic [mwr_pkg::SCAN_W-1:0]    scan_words;
        mwr_pkg::t_phase               phase;
        logic [mwr_pkg::CNT_W-1:0]     bit_cnt;
        logic [11:0]                   cmd_shift;
        logic [1:0]                    prev_bit;
        logic [mwr_pkg::WORD_W-1:0]    data_shift;
        logic [mwr_pkg::ADDR_IN_W-1:0] cur_addr;
        logic [mwr_pkg::WORD_W-1:0]    sum;
        logic                          scan_mode;
        logic                          sel_active;
        logic                          addr_section;
        logic [mwr_pkg::WORD_W-1:0]    last_word;
        mwr_pkg::t_out_item            expected_pins[$];
        int mismatches, ticks_in, results_out, reads, scans, ok_scans, words;

        function new();
            address_bits = mwr_pkg::ABITS_RESET;
            scan_words   = mwr_pkg::SCAN_RESET;
            phase        = mwr_pkg::PH_IDLE;
            bit_cnt      = '0;
            cmd_shift    = '0;
            prev_bit     = mwr_pkg::MARK_DIFF;
            data_shift   = '0;
            cur_addr     = '0;
            sum          = '0;
            scan_mode    = 1'b0;
            sel_active   = 1'b0;
            addr_section = 1'b0;
            last_word    = '0;
            mismatches   = 0;
            ticks_in     = 0;
            results_out  = 0;
            reads        = 0;
            scans        = 0;
            ok_scans     = 0;
            words        = 0;
        endfunction

        function void set_reg(logic idx, logic [mwr_pkg::PDATA_W-1:0] value);
            if (idx == mwr_pkg::REG_ABITS) begin
                address_bits = value[mwr_pkg::ABITS_W-1:0];
            end else begin
                scan_words = value[mwr_pkg::SCAN_W-1:0];
            end
        endfunction

        function int eff_addr_bits();
            if (address_bits < 1) return 1;
            if (address_bits > mwr_pkg::MAX_ADDR_BITS_DEF) return mwr_pkg::MAX_ADDR_BITS_DEF;
            return int'(address_bits);
        endfunction

        function int eff_scan_words();
            if (scan_words < 1) return 1;
            if (scan_words > mwr_pkg::SCAN_LIMIT) return mwr_pkg::SCAN_LIMIT;
            return int'(scan_words);
        endfunction

        function int section_len();
            return addr_section ? eff_addr_bits() : mwr_pkg::OPCODE_BITS;
        endfunction

        function logic out_bit();
            int len;
            len = section_len();
            if (int'(bit_cnt) >= len) return 1'b0;
            return cmd_shift[4'(len - 1 - int'(bit_cnt))];
        endfunction

        // pin levels and status for one tick; advances the sequencer
        function mwr_pkg::t_out_item next_pins(mwr_pkg::t_in_item it);
            mwr_pkg::t_out_item o;
            logic               b;
            o = '0;
            if (phase == mwr_pkg::PH_IDLE &&
                (it.action == mwr_pkg::ACT_READ || it.action == mwr_pkg::ACT_SCAN)) begin
                scan_mode = (it.action == mwr_pkg::ACT_SCAN);
                cur_addr  = scan_mode ? '0 : it.word_address;
                sum       = '0;
                phase     = mwr_pkg::PH_SELECT;
                if (scan_mode) scans++;
                else reads++;
            end
            o.busy_res = (phase != mwr_pkg::PH_IDLE);
            case (phase)
                mwr_pkg::PH_SELECT: begin
                    sel_active = 1'b1;
                    phase = mwr_pkg::PH_START0;
                end
                mwr_pkg::PH_START0: begin
                    o.serial_data_out = 1'b1;
                    phase = mwr_pkg::PH_START1;
                end
                mwr_pkg::PH_START1: begin
                    o.serial_data_out = 1'b1;
                    o.serial_clock = 1'b1;
                    phase = mwr_pkg::PH_START2;
                end
                mwr_pkg::PH_START2: begin
                    o.serial_data_out = 1'b1;
                    addr_section = 1'b0;
                    cmd_shift = {10'd0, mwr_pkg::READ_OPCODE};
                    bit_cnt = '0;
                    prev_bit = mwr_pkg::MARK_DIFF;
                    phase = mwr_pkg::PH_SEND;
                end
                mwr_pkg::PH_SEND: begin
                    b = out_bit();
                    o.serial_data_out = b;
                    // DO gets its own tick only when the level changes
                    if (prev_bit != {1'b0, b}) begin
                        prev_bit = {1'b0, b};
                        phase = mwr_pkg::PH_RISE;
                    end else begin
                        o.serial_clock = 1'b1;
                        phase = mwr_pkg::PH_FALL;
                    end
                end
                mwr_pkg::PH_RISE: begin
                    o.serial_data_out = out_bit();
                    o.serial_clock = 1'b1;
                    phase = mwr_pkg::PH_FALL;
                end
                mwr_pkg::PH_FALL: begin
                    o.serial_data_out = out_bit();
                    bit_cnt = bit_cnt + 1'b1;
                    if (int'(bit_cnt) >= section_len()) begin
                        bit_cnt = '0;
                        if (!addr_section) begin
                            addr_section = 1'b1;
                            cmd_shift = {2'b00, cur_addr};
                            prev_bit = mwr_pkg::MARK_DIFF;
                            phase = mwr_pkg::PH_SEND;
                        end else begin
                            data_shift = '0;
                            phase = mwr_pkg::PH_DRISE;
                        end
                    end else begin
                        phase = mwr_pkg::PH_SEND;
                    end
                end
                mwr_pkg::PH_DRISE: begin
                    o.serial_clock = 1'b1;
                    phase = mwr_pkg::PH_DFALL;
                end
                mwr_pkg::PH_DFALL: begin
                    phase = mwr_pkg::PH_DSAMPLE;
                end
                mwr_pkg::PH_DSAMPLE: begin
                    data_shift = {data_shift[mwr_pkg::WORD_W-2:0], it.serial_data_in};
                    bit_cnt = bit_cnt + 1'b1;
                    if (int'(bit_cnt) >= mwr_pkg::DATA_BITS_DEF) begin
                        bit_cnt = '0;
                        last_word = data_shift;
                        o.word_ready = 1'b1;
                        words++;
                        if (scan_mode) sum = sum + last_word;
                        phase = mwr_pkg::PH_DESELECT;
                    end else begin
                        phase = mwr_pkg::PH_DRISE;
                    end
                end
                mwr_pkg::PH_DESELECT: begin
                    sel_active = 1'b0;
                    if (scan_mode && int'(cur_addr) + 1 < eff_scan_words()) begin
                        cur_addr = cur_addr + 1'b1;
                        phase = mwr_pkg::PH_SELECT;
                    end else begin
                        if (scan_mode) begin
                            o.scan_done = 1'b1;
                            o.checksum_ok = (sum == '0);
                            if (sum == '0) ok_scans++;
                        end
                        scan_mode = 1'b0;
                        phase = mwr_pkg::PH_IDLE;
                    end
                end
                default: begin
                    sel_active = 1'b0;
                    o.busy_res = 1'b0;
                    phase = mwr_pkg::PH_IDLE;
                end
            endcase
            o.chip_select = sel_active;
            o.read_word = last_word;
            return o;
        endfunction

        task note_tick(mwr_pkg::t_in_item it);
            expected_pins.push_back(next_pins(it));
            ticks_in++;
        endtask

        task report(string what, logic [mwr_pkg::WORD_W-1:0] got,
                    logic [mwr_pkg::WORD_W-1:0] want);
            mismatches++;
            $display("mismatch at result %0d: %s got %h want %h",
                     results_out, what, got, want);
        endtask

        task compare(string what, logic [mwr_pkg::WORD_W-1:0] got,
                     logic [mwr_pkg::WORD_W-1:0] want);
            if (got !== want) report(what, got, want);
        endtask

        task check_pins(mwr_pkg::t_out_item got);
            mwr_pkg::t_out_item want;
            if (expected_pins.size() == 0) begin
                report("unexpected result word", got.read_word, '0);
                return;
            end
            want = expected_pins.pop_front();
            results_out++;
            compare("chip_select", mwr_pkg::WORD_W'(got.chip_select),
                    mwr_pkg::WORD_W'(want.chip_select));
            compare("serial_clock", mwr_pkg::WORD_W'(got.serial_clock),
                    mwr_pkg::WORD_W'(want.serial_clock));
            compare("serial_data_out", mwr_pkg::WORD_W'(got.serial_data_out),
                    mwr_pkg::WORD_W'(want.serial_data_out));
            compare("busy_res", mwr_pkg::WORD_W'(got.busy_res),
                    mwr_pkg::WORD_W'(want.busy_res));
            compare("word_ready", mwr_pkg::WORD_W'(got.word_ready),
                    mwr_pkg::WORD_W'(want.word_ready));
            compare("read_word", got.read_word, want.read_word);
            compare("scan_done", mwr_pkg::WORD_W'(got.scan_done),
                    mwr_pkg::WORD_W'(want.scan_done));
            compare("checksum_ok", mwr_pkg::WORD_W'(got.checksum_ok),
                    mwr_pkg::WORD_W'(want.checksum_ok));
        endtask
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    mwr_pkg::t_in_item             i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    mwr_pkg::t_out_item            o_out_data;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [mwr_pkg::PADDR_W-1:0]   paddr       = '0;
    logic [mwr_pkg::PDATA_W-1:0]   pwdata      = '0;
    logic [mwr_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    eeprom_pin_scoreboard          sb;
    logic [mwr_pkg::WORD_W-1:0]    eeprom_image [mwr_pkg::SCAN_LIMIT];
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests      = 0;
    int holds_served       = 0;
    int hold_left          = 0;
    int idle_cycles        = 0;
    int cfg_writes         = 0;

    microwire_eeprom_word_reader_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: random stall, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_pins(o_out_data);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) || psel) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_item(mwr_pkg::t_in_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_tick(it);
    endtask

    // tick, with random action codes when noisy; on a sample tick the data bit comes from the image
    function automatic mwr_pkg::t_in_item make_tick(bit noisy);
        mwr_pkg::t_in_item it;
        int                r;
        it.word_address = mwr_pkg::ADDR_IN_W'($urandom_range(1023));
        it.action = mwr_pkg::ACT_TICK;
        r = $urandom_range(99);
        if (noisy && r < 3) it.action = mwr_pkg::ACT_READ;
        else if (noisy && r < 6) it.action = mwr_pkg::ACT_SCAN;
        else if (noisy && r < 9) it.action = ACT_SPARE;
        if (sb.phase == mwr_pkg::PH_DSAMPLE) begin
            it.serial_data_in =
                eeprom_image[sb.cur_addr][4'(mwr_pkg::DATA_BITS_DEF - 1 - int'(sb.bit_cnt))];
        end else begin
            it.serial_data_in = 1'($urandom_range(1));
        end
        return it;
    endfunction

    function automatic logic [mwr_pkg::ADDR_IN_W-1:0] pick_address();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return mwr_pkg::ADDR_IN_W'($urandom_range(1023));
        endcase
    endfunction

    task automatic start_op(logic [1:0] act, logic [mwr_pkg::ADDR_IN_W-1:0] addr,
                            bit zero_sum);
        mwr_pkg::t_in_item          it;
        int                         n;
        logic [mwr_pkg::WORD_W-1:0] acc;
        if (act == mwr_pkg::ACT_SCAN) begin
            n = sb.eff_scan_words();
            acc = '0;
            for (int i = 0; i < n - 1; i++) begin
                eeprom_image[mwr_pkg::ADDR_IN_W'(i)] = mwr_pkg::WORD_W'($urandom);
                acc = acc + eeprom_image[mwr_pkg::ADDR_IN_W'(i)];
            end
            eeprom_image[mwr_pkg::ADDR_IN_W'(n - 1)] =
                zero_sum ? mwr_pkg::WORD_W'(-acc) : mwr_pkg::WORD_W'($urandom);
        end
        it = make_tick(1'b0);
        it.action = act;
        it.word_address = addr;
        send_item(it);
    endtask

    task automatic run_ticks(int n, bit noisy);
        repeat (n) send_item(make_tick(noisy));
    endtask

    task automatic finish_op(bit noisy);
        while (sb.phase != mwr_pkg::PH_IDLE) send_item(make_tick(noisy));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_pins.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [mwr_pkg::PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, value);
        cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic configure(int abits, int swords);
        write_reg(mwr_pkg::REG_ABITS, mwr_pkg::PDATA_W'(abits));
        write_reg(mwr_pkg::REG_SCAN, mwr_pkg::PDATA_W'(swords));
    endtask

    initial begin
        mwr_pkg::t_in_item           it;
        int                          goal;
        int                          r;
        logic [mwr_pkg::PDATA_W-1:0] v;
        sb = new();
        for (int i = 0; i < mwr_pkg::SCAN_LIMIT; i++) begin
            eeprom_image[mwr_pkg::ADDR_IN_W'(i)] = mwr_pkg::WORD_W'($urandom);
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle ticks, plain and with the unused action code
        send_item(make_tick(1'b0));
        it = make_tick(1'b0);
        it.action = ACT_SPARE;
        send_item(it);

        // reset configuration: 8 address bits, high address bits dropped
        eeprom_image[10'h3ff] = 16'hffff;
        start_op(mwr_pkg::ACT_READ, 10'h3ff, 1'b0);
        finish_op(1'b0);

        drain();
        configure(10, 1);
        eeprom_image[10'h000] = 16'h0000;
        eeprom_image[10'h155] = 16'ha5a5;
        eeprom_image[10'h2aa] = 16'h8001;
        start_op(mwr_pkg::ACT_READ, 10'h3ff, 1'b0);
        finish_op(1'b0);
        start_op(mwr_pkg::ACT_READ, 10'h000, 1'b0);
        finish_op(1'b0);
        start_op(mwr_pkg::ACT_READ, 10'h155, 1'b0);
        finish_op(1'b0);
        start_op(mwr_pkg::ACT_READ, 10'h2aa, 1'b0);
        finish_op(1'b0);

        // address width below and above range, then narrow widths
        drain();
        write_reg(mwr_pkg::REG_ABITS, 32'd0);
        start_op(mwr_pkg::ACT_READ, 10'h3ff, 1'b0);
        finish_op(1'b0);
        drain();
        write_reg(mwr_pkg::REG_ABITS, 32'd15);
        start_op(mwr_pkg::ACT_READ, 10'h3ff, 1'b0);
        finish_op(1'b0);
        drain();
        write_reg(mwr_pkg::REG_ABITS, 32'd1);
        start_op(mwr_pkg::ACT_READ, 10'h001, 1'b0);
        finish_op(1'b0);
        drain();
        write_reg(mwr_pkg::REG_ABITS, 32'd6);
        start_op(mwr_pkg::ACT_READ, 10'h3c0, 1'b0);
        finish_op(1'b0);

        // scans: zero length acts as one word, zero and nonzero sums
        drain();
        write_reg(mwr_pkg::REG_SCAN, 32'd0);
        start_op(mwr_pkg::ACT_SCAN, '0, 1'b1);
        finish_op(1'b0);
        drain();
        write_reg(mwr_pkg::REG_SCAN, 32'd3);
        start_op(mwr_pkg::ACT_SCAN, '0, 1'b1);
        finish_op(1'b0);
        drain();
        write_reg(mwr_pkg::REG_SCAN, 32'd2);
        start_op(mwr_pkg::ACT_SCAN, 10'h3ff, 1'b0);
        finish_op(1'b0);

        // starts and the unused code while busy are plain ticks
        start_op(mwr_pkg::ACT_READ, 10'h0f0, 1'b0);
        it = make_tick(1'b0);
        it.action = mwr_pkg::ACT_SCAN;
        send_item(it);
        it = make_tick(1'b0);
        it.action = mwr_pkg::ACT_READ;
        send_item(it);
        it = make_tick(1'b0);
        it.action = ACT_SPARE;
        send_item(it);
        finish_op(1'b1);

        // shrink the address width in the middle of the address bits
        drain();
        write_reg(mwr_pkg::REG_ABITS, 32'd10);
        start_op(mwr_pkg::ACT_READ, 10'h3ff, 1'b0);
        run_ticks(22, 1'b0);
        drain();
        write_reg(mwr_pkg::REG_ABITS, 32'hffff_fff4);
        finish_op(1'b0);

        // cut a scan short
        drain();
        write_reg(mwr_pkg::REG_SCAN, 32'd5);
        start_op(mwr_pkg::ACT_SCAN, '0, 1'b1);
        run_ticks(200, 1'b0);
        drain();
        write_reg(mwr_pkg::REG_SCAN, 32'd1);
        finish_op(1'b0);

        // random part
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
                default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
            endcase
            v = ($urandom_range(3) == 0) ? mwr_pkg::PDATA_W'($urandom) : '0;
            r = $urandom_range(99);
            v[mwr_pkg::ABITS_W-1:0] = (r < 70) ? mwr_pkg::ABITS_W'($urandom_range(10, 6)) :
                                                 mwr_pkg::ABITS_W'($urandom_range(15));
            write_reg(mwr_pkg::REG_ABITS, v);
            v = ($urandom_range(3) == 0) ? mwr_pkg::PDATA_W'($urandom) : '0;
            r = $urandom_range(99);
            if (r < 60) v[mwr_pkg::SCAN_W-1:0] = mwr_pkg::SCAN_W'($urandom_range(2, 1));
            else if (r < 80) v[mwr_pkg::SCAN_W-1:0] = mwr_pkg::SCAN_W'($urandom_range(4, 3));
            else if (r < 90) v[mwr_pkg::SCAN_W-1:0] = '0;
            else v[mwr_pkg::SCAN_W-1:0] = mwr_pkg::SCAN_W'($urandom_range(12, 5));
            write_reg(mwr_pkg::REG_SCAN, v);

            // receiver holds off while words keep coming
            if (p % 4 == 0) hold_requests++;
            goal = sb.ticks_in + RANDOM_ITEMS / RANDOM_PHASES;
            while (sb.ticks_in < goal) begin
                if (p % 4 == 3 && sb.ticks_in == goal - RANDOM_ITEMS / (2 * RANDOM_PHASES)) begin
                    drain();
                end
                if (sb.phase == mwr_pkg::PH_IDLE) begin
                    r = $urandom_range(99);
                    if (r < 55) start_op(mwr_pkg::ACT_READ, pick_address(), 1'b0);
                    else if (r < 90) begin
                        start_op(mwr_pkg::ACT_SCAN, pick_address(), 1'($urandom_range(1)));
                    end
                    else send_item(make_tick(1'b1));
                end else begin
                    send_item(make_tick(1'b1));
                end
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.expected_pins.size() != 0) begin
            sb.report("results never arrived", mwr_pkg::WORD_W'(sb.expected_pins.size()), '0);
        end
        $display("ran %0d ticks, checked %0d results: %0d reads, %0d scans (%0d summed to zero)",
                 sb.ticks_in, sb.results_out, sb.reads, sb.scans, sb.ok_scans);
        $display("%0d data words shifted in, %0d register writes, %0d mismatches",
                 sb.words, cfg_writes, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
